### design/fqd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fqd_pkg
// Shared sizes, codes and types of the FIFO queue with delete-by-value.
// ----------------------------------------------------------------------------
package fqd_pkg;

    localparam int DEPTH      = 16;
    localparam int VALUE_BITS = 32;

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    localparam int MODE_BITS     = 2;
    localparam int IN_VALUE_BITS = 32;
    localparam int OUT_VALUE_BITS = 32;
    localparam int COUNT_BITS    = 5;

    localparam logic [MODE_BITS-1:0] MODE_ENQ = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_DEQ = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_DEL = 2'd2;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    typedef struct packed {
        logic [MODE_BITS-1:0]     mode;
        logic [IN_VALUE_BITS-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic                      status;
        logic [OUT_VALUE_BITS-1:0] out_value;
        logic [COUNT_BITS-1:0]     count;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_DEQ_WAIT,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_SH_RD,
        ST_SH_WR,
        ST_DONE
    } t_state;

    // Commands from the sequencer to the datapath.
    typedef struct packed {
        logic load;      // capture a new request
        logic rd_en;     // read the slot at the selected offset
        logic rd_next;   // read offset is index + 1 instead of index
        logic wr_en;     // write a slot
        logic wr_tail;   // write the request value at the tail, else shift data at index
        logic idx_inc;
        logic head_inc;
        logic cnt_inc;
        logic cnt_dec;
        logic res_set;   // capture the result status
        logic res_err;
        logic res_data;  // result value comes from the read data
    } t_dp_ctrl;

    // Conditions from the datapath to the sequencer.
    typedef struct packed {
        logic is_enq;
        logic is_deq;
        logic is_del;
        logic val_zero;
        logic empty;
        logic full;
        logic match;     // read data equals the request value
        logic last;      // index + 1 equals the fill count
    } t_dp_stat;

endpackage
`default_nettype wire

### design/fqd_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fqd_datapath
// Slot memory kept as a ring, head pointer, fill count, scan index and the
// single data comparator used by the search.
// ----------------------------------------------------------------------------
module fqd_datapath (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire fqd_pkg::t_in_item i_req,
    input  wire fqd_pkg::t_dp_ctrl i_ctrl,
    output fqd_pkg::t_dp_stat      o_stat,
    output fqd_pkg::t_out_item     o_res
);
    import fqd_pkg::*;

    localparam int SUM_W = CNT_W + 1;

    logic [VALUE_BITS-1:0] r_mem [DEPTH];
    logic [VALUE_BITS-1:0] r_rdata;

    logic [ADDR_W-1:0]     r_head, n_head;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [CNT_W-1:0]      r_idx, n_idx;
    logic [MODE_BITS-1:0]  r_mode, n_mode;
    logic [VALUE_BITS-1:0] r_value, n_value;
    logic                  r_res_status, n_res_status;
    logic [VALUE_BITS-1:0] r_res_value, n_res_value;

    logic [CNT_W-1:0]      idx_plus;
    logic [CNT_W-1:0]      rd_off;
    logic [CNT_W-1:0]      wr_off;
    logic [ADDR_W-1:0]     rd_addr;
    logic [ADDR_W-1:0]     wr_addr;
    logic [VALUE_BITS-1:0] wr_data;

    // Offset from the head, wrapped into the ring. Both terms stay below DEPTH
    // plus one, so one conditional subtract is enough.
    function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] base,
                                                   input logic [CNT_W-1:0]  off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(off);
        if (sum >= SUM_W'(DEPTH)) begin
            sum = sum - SUM_W'(DEPTH);
        end
        return sum[ADDR_W-1:0];
    endfunction

    assign idx_plus = r_idx + CNT_W'(1);
    assign rd_off   = i_ctrl.rd_next ? idx_plus : r_idx;
    assign wr_off   = i_ctrl.wr_tail ? r_count : r_idx;
    assign rd_addr  = wrap_add(r_head, rd_off);
    assign wr_addr  = wrap_add(r_head, wr_off);
    assign wr_data  = i_ctrl.wr_tail ? r_value : r_rdata;

    always_comb begin
        n_head       = r_head;
        n_count      = r_count;
        n_idx        = r_idx;
        n_mode       = r_mode;
        n_value      = r_value;
        n_res_status = r_res_status;
        n_res_value  = r_res_value;
        if (i_ctrl.load) begin
            n_mode  = i_req.mode;
            n_value = VALUE_BITS'(i_req.value);
            n_idx   = '0;
        end
        if (i_ctrl.idx_inc) begin
            n_idx = idx_plus;
        end
        if (i_ctrl.head_inc) begin
            n_head = wrap_add(r_head, CNT_W'(1));
        end
        if (i_ctrl.cnt_inc) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_ctrl.cnt_dec) begin
            n_count = r_count - CNT_W'(1);
        end
        if (i_ctrl.res_set) begin
            n_res_status = i_ctrl.res_err;
            n_res_value  = i_ctrl.res_data ? r_rdata : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
            r_idx   <= '0;
            r_mode  <= MODE_ENQ;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
            r_idx   <= n_idx;
            r_mode  <= n_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value      <= n_value;
        r_res_status <= n_res_status;
        r_res_value  <= n_res_value;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_ctrl.rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_comb begin
        o_stat.is_enq   = (r_mode == MODE_ENQ);
        o_stat.is_deq   = (r_mode == MODE_DEQ);
        o_stat.is_del   = (r_mode == MODE_DEL);
        o_stat.val_zero = (r_value == '0);
        o_stat.empty    = (r_count == '0);
        o_stat.full     = (r_count == CNT_W'(DEPTH));
        o_stat.match    = (r_rdata == r_value);
        o_stat.last     = (idx_plus == r_count);
    end

    always_comb begin
        o_res.status    = r_res_status;
        o_res.out_value = OUT_VALUE_BITS'(r_res_value);
        o_res.count     = COUNT_BITS'(r_count);
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("fill count exceeds depth");
    a_no_inc_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.cnt_inc |-> (r_count != CNT_W'(DEPTH)))
        else $error("enqueue into a full queue");
    a_no_dec_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.cnt_dec || i_ctrl.rd_en) |-> (r_count != '0))
        else $error("slot access or removal on an empty queue");
`endif

endmodule
`default_nettype wire

### design/fqd_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fqd_ctrl
// Sequencer that steps the datapath through one request: decode, a read for
// dequeue, a read and compare loop for search, and a read and write loop that
// closes the gap after a deleted entry.
// ----------------------------------------------------------------------------
module fqd_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_fire,
    input  wire logic              i_out_free,
    input  wire fqd_pkg::t_dp_stat i_stat,
    output fqd_pkg::t_dp_ctrl      o_ctrl,
    output logic                   o_in_ready,
    output logic                   o_out_load
);
    import fqd_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_fire) begin
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (i_stat.is_deq && !i_stat.empty) begin
                    n_state = ST_DEQ_WAIT;
                end else if (i_stat.is_del && !i_stat.val_zero && !i_stat.empty) begin
                    n_state = ST_SRCH_RD;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_DEQ_WAIT: n_state = ST_DONE;
            ST_SRCH_RD:  n_state = ST_SRCH_CMP;
            ST_SRCH_CMP: begin
                if (i_stat.match) begin
                    n_state = ST_SH_RD;
                end else if (i_stat.last) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_SRCH_RD;
                end
            end
            ST_SH_RD: begin
                n_state = i_stat.last ? ST_DONE : ST_SH_WR;
            end
            ST_SH_WR: n_state = ST_SH_RD;
            ST_DONE: begin
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ctrl     = '0;
        o_in_ready = 1'b0;
        o_out_load = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready  = 1'b1;
                o_ctrl.load = i_in_fire;
            end
            ST_DECODE: begin
                if (i_stat.is_enq && !i_stat.val_zero && !i_stat.full) begin
                    o_ctrl.wr_en   = 1'b1;
                    o_ctrl.wr_tail = 1'b1;
                    o_ctrl.cnt_inc = 1'b1;
                    o_ctrl.res_set = 1'b1;
                    o_ctrl.res_err = STATUS_OK;
                end else if (i_stat.is_deq && !i_stat.empty) begin
                    o_ctrl.rd_en = 1'b1;
                end else if (i_stat.is_del && !i_stat.val_zero && !i_stat.empty) begin
                    o_ctrl.res_set = 1'b0;
                end else begin
                    o_ctrl.res_set = 1'b1;
                    o_ctrl.res_err = STATUS_ERR;
                end
            end
            ST_DEQ_WAIT: begin
                o_ctrl.res_set  = 1'b1;
                o_ctrl.res_err  = STATUS_OK;
                o_ctrl.res_data = 1'b1;
                o_ctrl.head_inc = 1'b1;
                o_ctrl.cnt_dec  = 1'b1;
            end
            ST_SRCH_RD: begin
                o_ctrl.rd_en = 1'b1;
            end
            ST_SRCH_CMP: begin
                if (!i_stat.match) begin
                    if (i_stat.last) begin
                        o_ctrl.res_set = 1'b1;
                        o_ctrl.res_err = STATUS_ERR;
                    end else begin
                        o_ctrl.idx_inc = 1'b1;
                    end
                end
            end
            ST_SH_RD: begin
                // Once the index reaches the newest entry the gap is closed.
                if (i_stat.last) begin
                    o_ctrl.cnt_dec = 1'b1;
                    o_ctrl.res_set = 1'b1;
                    o_ctrl.res_err = STATUS_OK;
                end else begin
                    o_ctrl.rd_en   = 1'b1;
                    o_ctrl.rd_next = 1'b1;
                end
            end
            ST_SH_WR: begin
                o_ctrl.wr_en   = 1'b1;
                o_ctrl.idx_inc = 1'b1;
            end
            ST_DONE: begin
                o_out_load = i_out_free;
            end
            default: begin
                o_ctrl = '0;
            end
        endcase
    end

endmodule
`default_nettype wire

### design/fifo_queue_with_delete_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fifo_queue_with_delete_unit
// Bounded FIFO of nonzero handles with enqueue, dequeue and delete by value.
// ----------------------------------------------------------------------------
// One request is taken at a time. Enqueue is done in the decode step,
// dequeue adds a read of the head slot, and delete of an entry takes longer
// the larger the queue, since the search and the gap close both pass
// through the slot memory, the search with one read per entry and the gap
// close with one read and write pair per entry. Errors on a null handle,
// full or empty queue return straight from decode. A new request is
// accepted while the previous result beat waits in the output register.
// ----------------------------------------------------------------------------
module fifo_queue_with_delete_unit (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire fqd_pkg::t_in_item  i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output fqd_pkg::t_out_item      o_out_data
);
    import fqd_pkg::*;

    t_dp_ctrl  dp_ctrl;
    t_dp_stat  dp_stat;
    t_out_item dp_res;

    logic      in_ready;
    logic      in_fire;
    logic      out_free;
    logic      out_load;

    logic      r_out_valid, n_out_valid;
    t_out_item r_out, n_out;

    assign in_fire  = i_in_valid && in_ready;
    assign out_free = !r_out_valid || !i_out_stall;

    fqd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_fire  (in_fire),
        .i_out_free (out_free),
        .i_stat     (dp_stat),
        .o_ctrl     (dp_ctrl),
        .o_in_ready (in_ready),
        .o_out_load (out_load)
    );

    fqd_datapath u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_in_data),
        .i_ctrl  (dp_ctrl),
        .o_stat  (dp_stat),
        .o_res   (dp_res)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (out_load) begin
            n_out_valid = 1'b1;
            n_out       = dp_res;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    // No request beat is taken while reset is held.
    assign o_in_stall  = !in_ready || !i_rst_n;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef ASSERT_OFF
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> out_free)
        else $error("result beat loaded over one not yet taken");
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> o_in_stall)
        else $error("request accepted while the previous one is in flight");
    a_beat_retires: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_stall && !out_load) |=> !o_out_valid)
        else $error("result beat repeated after it was taken");
`endif

endmodule
`default_nettype wire

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the FIFO queue with delete-by-value. A clocked
// driver feeds request beats from a pending list and predicts each result
// on acceptance; a clocked monitor checks result beats in order, field by
// field. Both sides idle at random in the first two of three phases.
// ----------------------------------------------------------------------------
module tb;

    import fqd_pkg::*;

    // The unused operation code; the block must reject it.
    localparam logic [MODE_BITS-1:0] MODE_BAD = 2'd3;

    localparam int RANDOM_ITEMS   = 550;
    localparam int STALL_LIMIT    = 4000;
    localparam int DRAIN_CYCLES   = 60;

    logic      i_clk     = 1'b0;
    logic      i_rst_n   = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_data   = '0;
    logic      out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_data;

    fifo_queue_with_delete_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    t_in_item  pending_reqs[$];
    t_out_item expected_results[$];
    int        error_count = 0;
    int        n_accepted  = 0;
    int        phase_len   = 1;
    int        tx_idle;
    int        rx_idle;
    int        quiet_cycles = 0;

    // Shadow of the queue contents, kept compacted with the oldest in slot 0.
    logic [VALUE_BITS-1:0] shadow_slots[DEPTH];
    int                    shadow_fill = 0;

    task automatic report_failure(input string msg);
        $display("mismatch: %s", msg);
        error_count++;
    endtask

    function automatic void remove_slot(input int pos);
        for (int i = pos; i + 1 < shadow_fill; i++)
            shadow_slots[i] = shadow_slots[i + 1];
        shadow_fill--;
    endfunction

    function automatic t_out_item apply_request(input t_in_item req);
        t_out_item res;
        res.status    = STATUS_ERR;
        res.out_value = '0;
        case (req.mode)
            MODE_ENQ: begin
                if (req.value != '0 && shadow_fill < DEPTH) begin
                    shadow_slots[shadow_fill] = req.value;
                    shadow_fill++;
                    res.status = STATUS_OK;
                end
            end
            MODE_DEQ: begin
                if (shadow_fill > 0) begin
                    res.out_value = shadow_slots[0];
                    remove_slot(0);
                    res.status = STATUS_OK;
                end
            end
            MODE_DEL: begin
                if (req.value != '0) begin
                    for (int i = 0; i < shadow_fill; i++) begin
                        if (shadow_slots[i] == req.value) begin
                            remove_slot(i);
                            res.status = STATUS_OK;
                            break;
                        end
                    end
                end
            end
            default: ;
        endcase
        res.count = COUNT_BITS'(shadow_fill);
        return res;
    endfunction

    task automatic queue_req(input logic [MODE_BITS-1:0] mode,
                             input logic [IN_VALUE_BITS-1:0] value);
        t_in_item it;
        it.mode  = mode;
        it.value = value;
        pending_reqs.push_back(it);
    endtask

    // Sender idles 34 and receiver 74 in a hundred, then swapped, then neither.
    always_comb begin
        if (n_accepted < phase_len) begin
            tx_idle = 34;
            rx_idle = 74;
        end else if (n_accepted < 2 * phase_len) begin
            tx_idle = 74;
            rx_idle = 34;
        end else begin
            tx_idle = 0;
            rx_idle = 0;
        end
    end

    // Request driver: a stalled beat holds; otherwise the next one may go out.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || !o_in_stall) begin
            if (in_valid) begin
                expected_results.push_back(apply_request(in_data));
                n_accepted++;
            end
            if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= tx_idle) begin
                in_valid <= 1'b1;
                in_data  <= pending_reqs.pop_front();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(0, 99) < rx_idle);
    end

    // Result monitor.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !out_stall) begin
            if (expected_results.size() == 0) begin
                report_failure($sformatf("result beat with nothing expected (count %0d)",
                                         o_out_data.count));
            end else begin
                want = expected_results.pop_front();
                if (o_out_data.status !== want.status)
                    report_failure($sformatf("status got %0b expected %0b",
                                             o_out_data.status, want.status));
                if (o_out_data.out_value !== want.out_value)
                    report_failure($sformatf("out_value got %08h expected %08h",
                                             o_out_data.out_value, want.out_value));
                if (o_out_data.count !== want.count)
                    report_failure($sformatf("count got %0d expected %0d",
                                             o_out_data.count, want.count));
            end
        end
    end

    // Watchdog on cycles in which neither channel moves a beat.
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && !o_in_stall) || (o_out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("[fifo_queue_with_delete_unit] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int enq_bias;
        int r;
        logic [MODE_BITS-1:0]     mode;
        logic [IN_VALUE_BITS-1:0] value;

        // Rejections on an empty queue, null handles and the unused code.
        queue_req(MODE_DEQ, 32'h1234_5678);
        queue_req(MODE_DEL, 32'd5);
        queue_req(MODE_ENQ, 32'd0);
        queue_req(MODE_DEL, 32'd0);
        queue_req(MODE_BAD, 32'hDEAD_BEEF);
        // Fill to the brim, with a duplicate and the extreme handles.
        queue_req(MODE_ENQ, 32'hFFFF_FFFF);
        queue_req(MODE_ENQ, 32'd1);
        queue_req(MODE_ENQ, 32'd7);
        queue_req(MODE_ENQ, 32'h8000_0000);
        queue_req(MODE_ENQ, 32'd7);
        queue_req(MODE_ENQ, 32'h5555_5555);
        queue_req(MODE_ENQ, 32'hAAAA_AAAA);
        for (int v = 3; v <= 11; v++)
            queue_req(MODE_ENQ, v == 7 ? 32'd12 : IN_VALUE_BITS'(v));
        queue_req(MODE_ENQ, 32'd13);
        // Delete the older duplicate, miss, delete the tail, dequeue, delete head.
        queue_req(MODE_DEL, 32'd7);
        queue_req(MODE_DEL, 32'd99);
        queue_req(MODE_DEL, 32'd11);
        queue_req(MODE_DEQ, 32'hFFFF_FFFF);
        queue_req(MODE_DEL, 32'd1);

        // Random part in stretches that lean toward filling or draining.
        enq_bias = 50;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 40 == 0)
                enq_bias = $urandom_range(15, 85);
            r = $urandom_range(0, 99);
            if (r < 4)
                mode = MODE_BAD;
            else if (r < 4 + (enq_bias * 96) / 100)
                mode = MODE_ENQ;
            else if ($urandom_range(0, 1) == 0)
                mode = MODE_DEQ;
            else
                mode = MODE_DEL;
            r = $urandom_range(0, 99);
            if (r < 5)
                value = '0;
            else if (r < 20)
                value = $urandom;
            else
                value = $urandom_range(1, 6);
            queue_req(mode, value);
        end
        phase_len = pending_reqs.size() / 3;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_reqs.size() > 0 || in_valid)
            @(posedge i_clk);
        while (expected_results.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (expected_results.size() > 0)
            report_failure($sformatf("%0d results never arrived", expected_results.size()));
        if (error_count == 0)
            $display("[fifo_queue_with_delete_unit] OK");
        else
            $display("[fifo_queue_with_delete_unit] ERROR");
        $finish;
    end

endmodule
